### design/assert_macros.svh
// Assertion macros used by the checker file of the timestamp converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent check on a given clock and active-low reset.
`define ITSE_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error(msg);
// Same check on the block's own clock and reset.
`define ITSE_ASSERT(lbl, prop, msg) \
  `ITSE_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`endif

### design/itse_pkg.sv
// Shared types, constants and tables of the timestamp-to-epoch converter.
`default_nettype none
package itse_pkg;

  // Parsed timestamp handed from the parser to the converter.
  typedef struct packed {
    logic              ok;
    logic signed [14:0] year;
    logic [3:0]        month;
    logic [4:0]        day;
    logic [4:0]        hour;
    logic [5:0]        minute;
    logic [5:0]        second;
  } rec_t;

  // Queue between parser and converter
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Bounds of a valid result (year -999 up to year 9999)
  localparam logic signed [38:0] EpochMax = 39'sd253402300800;
  localparam logic signed [38:0] EpochMin = -39'sd93700000000;

  // Days in the shifted year (March first) before month index mp.
  function automatic logic [8:0] days_before(input logic [3:0] mp);
    logic [8:0] d;
    case (mp)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd61;
      4'd3:    d = 9'd92;
      4'd4:    d = 9'd122;
      4'd5:    d = 9'd153;
      4'd6:    d = 9'd184;
      4'd7:    d = 9'd214;
      4'd8:    d = 9'd245;
      4'd9:    d = 9'd275;
      4'd10:   d = 9'd306;
      4'd11:   d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

### design/itse_parser.sv
// Character parser: scans the timestamp text and builds the parsed record.
`default_nettype none
module itse_parser (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      char_byte_i,
  input  logic            has_char_i,
  input  logic            last_i,
  output itse_pkg::rec_t  rec_o
);

  // Field phases
  localparam logic [1:0] PhSpace  = 2'd0;
  localparam logic [1:0] PhSign   = 2'd1;
  localparam logic [1:0] PhDigits = 2'd2;
  localparam logic [1:0] PhSep    = 2'd3;

  // Field indexes
  localparam logic [2:0] IdxYear   = 3'd0;
  localparam logic [2:0] IdxMonth  = 3'd1;
  localparam logic [2:0] IdxDay    = 3'd2;
  localparam logic [2:0] IdxHour   = 3'd3;
  localparam logic [2:0] IdxMinute = 3'd4;
  localparam logic [2:0] IdxSecond = 3'd5;

  // Characters
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChT     = 8'h54;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChNul   = 8'h00;

  logic [2:0]         idx_q, idx_a;
  logic [1:0]         ph_q, ph_a;
  logic [2:0]         dig_q, dig_a;
  logic               neg_q, neg_a;
  logic [13:0]        acc_q, acc_a;
  logic               fail_q, fail_a;
  logic               done_q, done_a;
  logic signed [14:0] year_q, year_d;
  logic signed [7:0]  month_q, month_d;
  logic signed [7:0]  day_q, day_d;
  logic signed [7:0]  hour_q, hour_d;
  logic signed [7:0]  minute_q, minute_d;
  logic signed [7:0]  second_q, second_d;

  logic               is_space, is_digit, is_sign, is_nul;
  logic [3:0]         digit_val;
  logic [2:0]         width_lim, dig_inc;
  logic [7:0]         sep_char;
  logic [13:0]        acc_sum;
  logic               take_commit, take_sep, nul_end, fin_commit, com_en;
  logic [13:0]        com_acc;
  logic               com_neg;
  logic signed [14:0] year_val;
  logic signed [7:0]  small_val;

  // Character classes
  assign is_space  = (char_byte_i == ChSpace) ||
                     (char_byte_i >= ChTab && char_byte_i <= ChCr);
  assign is_digit  = (char_byte_i >= ChZero) && (char_byte_i <= ChNine);
  assign is_sign   = (char_byte_i == ChPlus) || (char_byte_i == ChMinus);
  assign is_nul    = (char_byte_i == ChNul);
  assign digit_val = char_byte_i[3:0];

  // Field width counts the sign; separator expected after the current field
  assign width_lim = (idx_q == IdxYear) ? 3'd4 : 3'd2;
  assign dig_inc   = dig_q + 3'd1;
  assign sep_char  = (idx_q == IdxDay) ? ChT : ((idx_q < IdxDay) ? ChMinus : ChColon);
  assign acc_sum   = acc_q * 14'd10 + {10'b0, digit_val};

  // Scan step: take the character, then close the text on end or NUL
  always_comb begin
    idx_a       = idx_q;
    ph_a        = ph_q;
    dig_a       = dig_q;
    neg_a       = neg_q;
    acc_a       = acc_q;
    fail_a      = fail_q;
    done_a      = done_q;
    take_commit = 1'b0;
    take_sep    = 1'b0;
    nul_end     = 1'b0;
    fin_commit  = 1'b0;

    if (has_char_i && !fail_q && !done_q) begin
      if (is_nul) begin
        nul_end = 1'b1;
      end else begin
        unique case (ph_q)
          PhSpace: begin
            if (!is_space) begin
              if (is_sign) begin
                neg_a = (char_byte_i == ChMinus);
                dig_a = 3'd1;
                ph_a  = PhSign;
              end else if (is_digit) begin
                acc_a = {10'b0, digit_val};
                dig_a = 3'd1;
                ph_a  = PhDigits;
              end else begin
                fail_a = 1'b1;
              end
            end
          end
          PhSign: begin
            if (is_digit) begin
              acc_a       = {10'b0, digit_val};
              dig_a       = dig_inc;
              ph_a        = PhDigits;
              take_commit = (dig_inc >= width_lim);
            end else begin
              fail_a = 1'b1;
            end
          end
          PhDigits: begin
            if (is_digit) begin
              acc_a       = acc_sum;
              dig_a       = dig_inc;
              take_commit = (dig_inc >= width_lim);
            end else begin
              take_commit = 1'b1;
              take_sep    = (idx_q != IdxSecond);
            end
          end
          PhSep: begin
            take_sep = 1'b1;
          end
          default: begin
            fail_a = 1'b1;
          end
        endcase
      end
    end

    // Number value as it stands before the field closes
    com_acc = acc_a;
    com_neg = neg_a;

    // Close the field
    if (take_commit) begin
      acc_a = '0;
      dig_a = '0;
      neg_a = 1'b0;
      if (idx_q == IdxSecond) begin
        done_a = 1'b1;
      end else begin
        ph_a = PhSep;
      end
    end

    // Separator match
    if (take_sep) begin
      if (char_byte_i == sep_char) begin
        idx_a = idx_q + 3'd1;
        ph_a  = PhSpace;
      end else begin
        fail_a = 1'b1;
      end
    end

    // End of text: seconds may end with the string
    if ((last_i || nul_end) && !fail_a && !done_a) begin
      if (idx_a == IdxSecond && ph_a == PhDigits) begin
        fin_commit = 1'b1;
        done_a     = 1'b1;
        acc_a      = '0;
        dig_a      = '0;
        neg_a      = 1'b0;
      end else begin
        fail_a = 1'b1;
      end
    end
  end

  // Signed field value
  always_comb begin
    year_val  = {1'b0, com_acc};
    small_val = {1'b0, com_acc[6:0]};
    if (com_neg) begin
      year_val  = -year_val;
      small_val = -small_val;
    end
  end

  // Field store
  assign com_en = take_commit | fin_commit;

  always_comb begin
    year_d   = year_q;
    month_d  = month_q;
    day_d    = day_q;
    hour_d   = hour_q;
    minute_d = minute_q;
    second_d = second_q;
    if (com_en) begin
      unique case (idx_q)
        IdxYear:   year_d   = year_val;
        IdxMonth:  month_d  = small_val;
        IdxDay:    day_d    = small_val;
        IdxHour:   hour_d   = small_val;
        IdxMinute: minute_d = small_val;
        default:   second_d = small_val;
      endcase
    end
  end

  // Record with range checks, taken when the string ends
  always_comb begin
    rec_o.ok     = done_a && !fail_a &&
                   month_d >= 8'sd1 && month_d <= 8'sd12 &&
                   day_d >= 8'sd1 && day_d <= 8'sd31 &&
                   hour_d >= 8'sd0 && hour_d <= 8'sd23 &&
                   minute_d >= 8'sd0 && minute_d <= 8'sd59 &&
                   second_d >= 8'sd0 && second_d <= 8'sd60;
    rec_o.year   = year_d;
    rec_o.month  = month_d[3:0];
    rec_o.day    = day_d[4:0];
    rec_o.hour   = hour_d[4:0];
    rec_o.minute = minute_d[5:0];
    rec_o.second = second_d[5:0];
  end

  // Scan state; a string end returns everything to its start values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= IdxYear;
      ph_q     <= PhSpace;
      dig_q    <= '0;
      neg_q    <= 1'b0;
      acc_q    <= '0;
      fail_q   <= 1'b0;
      done_q   <= 1'b0;
      year_q   <= '0;
      month_q  <= '0;
      day_q    <= '0;
      hour_q   <= '0;
      minute_q <= '0;
      second_q <= '0;
    end else if (accept_i) begin
      if (last_i) begin
        idx_q    <= IdxYear;
        ph_q     <= PhSpace;
        dig_q    <= '0;
        neg_q    <= 1'b0;
        acc_q    <= '0;
        fail_q   <= 1'b0;
        done_q   <= 1'b0;
        year_q   <= '0;
        month_q  <= '0;
        day_q    <= '0;
        hour_q   <= '0;
        minute_q <= '0;
        second_q <= '0;
      end else begin
        idx_q    <= idx_a;
        ph_q     <= ph_a;
        dig_q    <= dig_a;
        neg_q    <= neg_a;
        acc_q    <= acc_a;
        fail_q   <= fail_a;
        done_q   <= done_a;
        year_q   <= year_d;
        month_q  <= month_d;
        day_q    <= day_d;
        hour_q   <= hour_d;
        minute_q <= minute_d;
        second_q <= second_d;
      end
    end
  end

endmodule
`default_nettype wire

### design/itse_fifo.sv
// Short queue of parsed records between the parser and the converter.
`default_nettype none
module itse_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  itse_pkg::rec_t rec_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           empty_o,
  output itse_pkg::rec_t rec_o
);

  itse_pkg::rec_t                  mem_q [itse_pkg::QDepth];
  logic [itse_pkg::QPtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [itse_pkg::QCntW-1:0]      cnt_q, cnt_d;
  logic                            wr_en, rd_en;

  assign full_o  = (cnt_q == itse_pkg::QCntW'(itse_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign wr_en   = push_i & ~full_o;
  assign rd_en   = pop_i & ~empty_o;
  assign rec_o   = mem_q[rd_ptr_q];

  // Occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // Pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

endmodule
`default_nettype wire

### design/itse_convert.sv
// Converter: days-from-civil and seconds arithmetic over a short sequence.
`default_nettype none
module itse_convert (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  itse_pkg::rec_t      q_rec_i,
  output logic                q_pop_o,
  input  logic                pop_i,
  output logic                empty_o,
  output logic signed [38:0]  epoch_seconds_o,
  output logic                valid_res_o
);

  // Sequencer states
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StDiv  = 3'd1;
  localparam logic [2:0] StRem  = 3'd2;
  localparam logic [2:0] StDoe  = 3'd3;
  localparam logic [2:0] StDays = 3'd4;
  localparam logic [2:0] StSecs = 3'd5;
  localparam logic [2:0] StDone = 3'd6;

  // Year offset keeps the era division non-negative (three eras)
  localparam logic signed [14:0] YearBias   = 15'sd1200;
  localparam logic [15:0]        RecipM     = 16'd41944;   // ceil(2^24 / 400)
  localparam logic [13:0]        YearsEra   = 14'd400;
  localparam logic signed [5:0]  EraBias    = 6'sd3;
  localparam logic signed [18:0] DaysPerEra = 19'sd146097;
  localparam logic signed [23:0] DaysOffset = 24'sd719468;
  localparam logic signed [17:0] SecsPerDay = 18'sd86400;

  logic [2:0]          state_q, state_d;
  logic                out_valid_q;
  logic                pop_acc, out_wr;

  logic                ok_q;
  logic [13:0]         u_q;
  logic [3:0]          mp_q;
  logic [4:0]          day_q, hour_q;
  logic [5:0]          min_q, sec_q;
  logic [4:0]          quo_q;
  logic signed [5:0]   era_q;
  logic [8:0]          yoe_q;
  logic [17:0]         doe_q;
  logic signed [23:0]  era_days_q, days_q;
  logic signed [38:0]  secs_day_q;
  logic [16:0]         tod_q;
  logic signed [38:0]  out_epoch_q;
  logic                out_ok_q;

  logic signed [14:0]  y_adj, u_full;
  logic [3:0]          mp_d;
  logic [29:0]         q_prod;
  logic [13:0]         q_x400, rem, rem_c;
  logic [4:0]          quo_c;
  logic [8:0]          yoe_d;
  logic signed [5:0]   era_d;
  logic [17:0]         yoe18, doe_d;
  logic [1:0]          cent;
  logic signed [24:0]  era_prod;
  logic signed [23:0]  days_d;
  logic signed [41:0]  secs_prod;
  logic [16:0]         tod_d;
  logic signed [38:0]  sum_d;

  assign pop_acc         = pop_i & out_valid_q;
  assign empty_o         = ~out_valid_q;
  assign epoch_seconds_o = out_epoch_q;
  assign valid_res_o     = out_ok_q;
  assign q_pop_o         = (state_q == StIdle) && !q_empty_i;
  assign out_wr          = (state_q == StDone) && (!out_valid_q || pop_acc);

  // Load: year shifted to March start, biased non-negative
  always_comb begin
    y_adj  = q_rec_i.year - ((q_rec_i.month <= 4'd2) ? 15'sd1 : 15'sd0);
    u_full = y_adj + YearBias;
    mp_d   = (q_rec_i.month > 4'd2) ? (q_rec_i.month - 4'd3) : (q_rec_i.month + 4'd9);
  end

  // Era quotient by reciprocal, remainder with one correction
  always_comb begin
    q_prod = u_q * RecipM;
    q_x400 = {9'b0, quo_q} * YearsEra;
    rem    = u_q - q_x400;
    rem_c  = rem - YearsEra;
    if (rem >= YearsEra) begin
      yoe_d = rem_c[8:0];
      quo_c = quo_q + 5'd1;
    end else begin
      yoe_d = rem[8:0];
      quo_c = quo_q;
    end
    era_d = $signed({1'b0, quo_c}) - EraBias;
  end

  // Day of era and era base
  always_comb begin
    yoe18 = {9'b0, yoe_q};
    if (yoe_q >= 9'd300) begin
      cent = 2'd3;
    end else if (yoe_q >= 9'd200) begin
      cent = 2'd2;
    end else if (yoe_q >= 9'd100) begin
      cent = 2'd1;
    end else begin
      cent = 2'd0;
    end
    doe_d    = yoe18 * 18'd365 + {2'b0, yoe18[17:2]} - {16'b0, cent} +
               {9'b0, itse_pkg::days_before(mp_q)} + {13'b0, day_q} - 18'd1;
    era_prod = era_q * DaysPerEra;
  end

  // Days since epoch, seconds of the day, final sum
  always_comb begin
    days_d    = era_days_q + $signed({6'b0, doe_q}) - DaysOffset;
    secs_prod = days_q * SecsPerDay;
    tod_d     = {12'b0, hour_q} * 17'd3600 + {11'b0, min_q} * 17'd60 + {11'b0, sec_q};
    sum_d     = secs_day_q + $signed({22'b0, tod_q});
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (!q_empty_i) state_d = StDiv;
      StDiv:   state_d = StRem;
      StRem:   state_d = StDoe;
      StDoe:   state_d = StDays;
      StDays:  state_d = StSecs;
      StSecs:  state_d = StDone;
      StDone:  if (out_wr) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_wr) begin
        out_valid_q <= 1'b1;
      end else if (pop_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      ok_q   <= q_rec_i.ok;
      u_q    <= u_full[13:0];
      mp_q   <= mp_d;
      day_q  <= q_rec_i.day;
      hour_q <= q_rec_i.hour;
      min_q  <= q_rec_i.minute;
      sec_q  <= q_rec_i.second;
    end
    if (state_q == StDiv) begin
      quo_q <= q_prod[28:24];
    end
    if (state_q == StRem) begin
      yoe_q <= yoe_d;
      era_q <= era_d;
    end
    if (state_q == StDoe) begin
      doe_q      <= doe_d;
      era_days_q <= era_prod[23:0];
    end
    if (state_q == StDays) begin
      days_q <= days_d;
    end
    if (state_q == StSecs) begin
      secs_day_q <= secs_prod[38:0];
      tod_q      <= tod_d;
    end
    if (out_wr) begin
      out_epoch_q <= ok_q ? sum_d : '0;
      out_ok_q    <= ok_q;
    end
  end

endmodule
`default_nettype wire

### design/iso_timestamp_to_epoch_seconds.sv
// Timestamp text to UTC epoch seconds: top level.
// One character word per cycle unless full; full rises only when the queue holds two strings.
// The last character queues its record; the states Div, Rem, Doe, Days and Secs compute the result.
// Done waits for a free output; records pop only in Idle; the 2-entry queue absorbs short strings.
// Reset (rst_ni low, asynchronous) empties the queue and output, and restarts the scan.
`default_nettype none
module iso_timestamp_to_epoch_seconds (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         char_byte_i,
  input  logic               has_char_i,
  input  logic               last_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [38:0] epoch_seconds_o,
  output logic               valid_res_o
);

  logic           accept;
  logic           q_empty, q_pop;
  itse_pkg::rec_t rec, q_rec;

  assign accept = push & ~full;

  // Front: character scanner
  itse_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .char_byte_i (char_byte_i),
    .has_char_i  (has_char_i),
    .last_i      (last_i),
    .rec_o       (rec)
  );

  // Record queue
  itse_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept & last_i),
    .rec_i   (rec),
    .pop_i   (q_pop),
    .full_o  (full),
    .empty_o (q_empty),
    .rec_o   (q_rec)
  );

  // Back: date conversion
  itse_convert u_convert (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_rec_i         (q_rec),
    .q_pop_o         (q_pop),
    .pop_i           (pop),
    .empty_o         (empty),
    .epoch_seconds_o (epoch_seconds_o),
    .valid_res_o     (valid_res_o)
  );

endmodule
`default_nettype wire

### design/itse_checker.sv
// Port-level checks of the timestamp converter, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module itse_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               empty,
  input logic               pop,
  input logic signed [38:0] epoch_seconds_o,
  input logic               valid_res_o
);

  // An invalid result word carries zero seconds
  `ITSE_ASSERT(a_invalid_zero, (!empty && !valid_res_o) |-> (epoch_seconds_o == '0), "invalid result with nonzero seconds")

  // A waiting result word holds until popped
  `ITSE_ASSERT(a_result_hold, (!empty && !pop) |=> (!empty && $stable(epoch_seconds_o) && $stable(valid_res_o)), "waiting result changed")

  // A valid result lies between year -999 and the end of year 9999
  `ITSE_ASSERT(a_valid_range, (!empty && valid_res_o) |-> (epoch_seconds_o >= itse_pkg::EpochMin && epoch_seconds_o <= itse_pkg::EpochMax), "valid result out of range")

endmodule

bind iso_timestamp_to_epoch_seconds itse_checker u_itse_checker (.*);
`default_nettype wire
